@@ rtl/stream_substring_replace_macros.svh @@
// Assertion macros for the substring replace block.
`ifndef STREAM_SUBSTRING_REPLACE_MACROS_SVH
`define STREAM_SUBSTRING_REPLACE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every edge outside reset.
`define SSR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SSR_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/ssr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the substring replace block.
package ssr_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int REPLACE_MAX = 16;
   localparam int OUT_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX + 1
                                                            : REPLACE_MAX + 1;
   localparam int EXT_MAX     = OUT_MAX + 2;

   localparam int BYTE_W     = 8;
   localparam int CFG_DATA_W = 64;
   localparam int CFG_LEN_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CNT_W      = $clog2(PATTERN_MAX + 1);
   localparam int RLEN_W     = $clog2(REPLACE_MAX + 1);
   localparam int BURST_W    = $clog2(OUT_MAX + 1);

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_FIRST     = 3'd0,
      CSR_PATTERN_LAST      = 3'd1,
      CSR_PATTERN_LENGTH    = 3'd2,
      CSR_REPLACEMENT_FIRST = 3'd3,
      CSR_REPLACEMENT_LAST  = 3'd4,
      CSR_REPLACEMENT_LENGTH = 3'd5
   } csr_index_type;

endpackage

@@ rtl/ssr_intf.sv @@
`timescale 1ns / 1ps
// Stream and register-write channel interfaces of the substring replace block.
interface ssr_req_if import ssr_pkg::*;;
   logic     valid;
   logic     ready;
   byte_type in_byte;
   logic     in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ssr_rsp_if import ssr_pkg::*;;
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     out_valid;
   logic     out_last;
   logic     replaced;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   output replaced, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input out_last,
                   input replaced, output ready);
endinterface

interface ssr_csr_if import ssr_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CFG_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/stream_substring_replace.sv @@
`timescale 1ns / 1ps
// Top level of the streaming first-occurrence substring replace block.
//
// Bytes of a string enter on req_ch, one word per byte, in_last on the final
// byte. Results leave on rsp_ch: passed-through bytes, held window bytes and
// replacement bytes in order; the final result of a string carries out_last
// and the replaced flag. A string whose output is empty ends with one marker
// word that has out_valid low. csr_ch writes the six registers (index 0 to 5);
// it is always ready and must be used only while the block is idle.
// Each accepted word is worked out combinationally into a burst register, and
// its first result shows on rsp_ch the next cycle. The burst drains one result
// a cycle while the receiver is ready; a word causes k results (k is 0 to 17).
// A new word is taken in the cycle the burst's last result is taken, or at once
// if the burst is empty: with at most one result per word and a ready
// receiver the block runs at one word per cycle. When the receiver stalls,
// the burst holds and req_ch stays not ready. Reset clears the window, the
// registers and any pending burst.
`include "stream_substring_replace_macros.svh"

module stream_substring_replace import ssr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ssr_req_if.sink    req_ch,
   ssr_rsp_if.source  rsp_ch,
   ssr_csr_if.sink    csr_ch
);

   // configuration registers
   logic [CFG_DATA_W-1:0] pat_lo_ff, pat_lo_in;
   logic [CFG_DATA_W-1:0] pat_hi_ff, pat_hi_in;
   logic [CFG_DATA_W-1:0] rep_lo_ff, rep_lo_in;
   logic [CFG_DATA_W-1:0] rep_hi_ff, rep_hi_in;
   logic [CFG_LEN_W-1:0]  plen_cfg_ff, plen_cfg_in;
   logic [CFG_LEN_W-1:0]  rlen_cfg_ff, rlen_cfg_in;

   // window state
   byte_type         win_ff [PATTERN_MAX];
   byte_type         win_in [PATTERN_MAX];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   // result burst
   byte_type           buf_ff [OUT_MAX];
   byte_type           buf_in [OUT_MAX];
   logic [BURST_W-1:0] blen_ff, blen_in;
   logic               bvalid_ff, bvalid_in;
   logic               blast_ff, blast_in;
   logic               brepl_ff, brepl_in;

   // step logic
   logic [2*CFG_DATA_W-1:0] pat_word, rep_word;
   byte_type           pat [PATTERN_MAX];
   byte_type           win_ext [EXT_MAX];
   byte_type           rep_ext [OUT_MAX+1];
   byte_type           nw [PATTERN_MAX];
   byte_type           buf_pass [OUT_MAX];
   byte_type           buf_hit [OUT_MAX];
   logic [CNT_W-1:0]   plen, keep, nc;
   logic [RLEN_W-1:0]  rlen;
   logic [1:0]         drop;
   logic               pass_mode, do_cmp, eq, hit;
   logic [BURST_W-1:0] step_len;
   logic               step_vflag;

   logic req_fire, rsp_fire, rsp_valid, req_ready, final_rsp;

   assign rsp_valid = (blen_ff != '0);
   assign req_ready = (blen_ff == '0) || ((blen_ff == BURST_W'(1)) && rsp_ch.ready);
   assign req_fire  = req_ch.valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ch.ready;
   assign final_rsp = blast_ff && (blen_ff == BURST_W'(1));

   assign req_ch.ready    = req_ready;
   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.out_byte = bvalid_ff ? buf_ff[0] : '0;
   assign rsp_ch.out_valid = bvalid_ff;
   assign rsp_ch.out_last = final_rsp;
   assign rsp_ch.replaced = final_rsp && brepl_ff;
   assign csr_ch.ready    = 1'b1;

   assign pat_word = {pat_hi_ff, pat_lo_ff};
   assign rep_word = {rep_hi_ff, rep_lo_ff};
   assign plen = (plen_cfg_ff > CFG_LEN_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX)
                                                         : plen_cfg_ff[CNT_W-1:0];
   assign rlen = (rlen_cfg_ff > CFG_LEN_W'(REPLACE_MAX)) ? RLEN_W'(REPLACE_MAX)
                                                         : rlen_cfg_ff[RLEN_W-1:0];

   // configuration writes
   always_comb begin
      pat_lo_in   = pat_lo_ff;
      pat_hi_in   = pat_hi_ff;
      plen_cfg_in = plen_cfg_ff;
      rep_lo_in   = rep_lo_ff;
      rep_hi_in   = rep_hi_ff;
      rlen_cfg_in = rlen_cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_PATTERN_FIRST:      pat_lo_in   = csr_ch.data;
            CSR_PATTERN_LAST:       pat_hi_in   = csr_ch.data;
            CSR_PATTERN_LENGTH:     plen_cfg_in = csr_ch.data[CFG_LEN_W-1:0];
            CSR_REPLACEMENT_FIRST:  rep_lo_in   = csr_ch.data;
            CSR_REPLACEMENT_LAST:   rep_hi_in   = csr_ch.data;
            CSR_REPLACEMENT_LENGTH: rlen_cfg_in = csr_ch.data[CFG_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // one step of the window: drop, shift in, compare, build the burst
   always_comb begin
      for (int i = 0; i < EXT_MAX; i++) win_ext[i] = '0;
      for (int i = 0; i < PATTERN_MAX; i++) win_ext[i] = win_ff[i];
      for (int i = 0; i < PATTERN_MAX; i++) pat[i] = pat_word[8*i +: 8];

      // slot 0 holds the oldest window byte for a match that pops one first
      for (int i = 0; i < OUT_MAX + 1; i++) rep_ext[i] = '0;
      rep_ext[0] = win_ff[0];
      for (int i = 0; i < REPLACE_MAX; i++) rep_ext[i+1] = rep_word[8*i +: 8];

      pass_mode = done_ff || (plen == '0);
      if (cnt_ff > plen) drop = 2'd2;
      else if (cnt_ff == plen) drop = 2'd1;
      else drop = 2'd0;
      keep = cnt_ff - CNT_W'(drop);
      nc   = keep + CNT_W'(1);

      for (int i = 0; i < PATTERN_MAX; i++)
         nw[i] = (i < keep) ? win_ext[i + int'(drop)] : req_ch.in_byte;

      do_cmp = !pass_mode && (drop != 2'd2) && (nc == plen);
      eq = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++)
         if ((i < plen) && (nw[i] != pat[i])) eq = 1'b0;
      hit = do_cmp && eq;

      for (int j = 0; j < OUT_MAX; j++) begin
         buf_pass[j] = (j < cnt_ff) ? win_ext[j] : req_ch.in_byte;
         buf_hit[j]  = (drop == 2'd1) ? rep_ext[j] : rep_ext[j+1];
      end

      if (hit) step_len = BURST_W'(drop) + BURST_W'(rlen);
      else if (pass_mode || req_ch.in_last) step_len = BURST_W'(cnt_ff) + BURST_W'(1);
      else step_len = BURST_W'(drop);

      // empty output at end of string: send a lone end marker
      step_vflag = 1'b1;
      if (req_ch.in_last && (step_len == '0)) begin
         step_len   = BURST_W'(1);
         step_vflag = 1'b0;
      end
   end

   // state and burst next values
   always_comb begin
      win_in    = win_ff;
      cnt_in    = cnt_ff;
      done_in   = done_ff;
      buf_in    = buf_ff;
      blen_in   = blen_ff;
      bvalid_in = bvalid_ff;
      blast_in  = blast_ff;
      brepl_in  = brepl_ff;
      if (req_fire) begin
         win_in    = nw;
         buf_in    = hit ? buf_hit : buf_pass;
         blen_in   = step_len;
         bvalid_in = step_vflag;
         blast_in  = req_ch.in_last;
         brepl_in  = done_ff || hit;
         if (req_ch.in_last) begin
            cnt_in  = '0;
            done_in = 1'b0;
         end else if (pass_mode) begin
            cnt_in = '0;
         end else if (hit) begin
            cnt_in  = '0;
            done_in = 1'b1;
         end else begin
            cnt_in = nc;
         end
      end else if (rsp_fire) begin
         // advance the burst by one word
         for (int j = 0; j < OUT_MAX - 1; j++) buf_in[j] = buf_ff[j+1];
         buf_in[OUT_MAX-1] = '0;
         blen_in = blen_ff - BURST_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff   <= '0;
         pat_hi_ff   <= '0;
         plen_cfg_ff <= '0;
         rep_lo_ff   <= '0;
         rep_hi_ff   <= '0;
         rlen_cfg_ff <= '0;
         cnt_ff      <= '0;
         done_ff     <= 1'b0;
         blen_ff     <= '0;
         bvalid_ff   <= 1'b0;
         blast_ff    <= 1'b0;
         brepl_ff    <= 1'b0;
      end else begin
         pat_lo_ff   <= pat_lo_in;
         pat_hi_ff   <= pat_hi_in;
         plen_cfg_ff <= plen_cfg_in;
         rep_lo_ff   <= rep_lo_in;
         rep_hi_ff   <= rep_hi_in;
         rlen_cfg_ff <= rlen_cfg_in;
         cnt_ff      <= cnt_in;
         done_ff     <= done_in;
         blen_ff     <= blen_in;
         bvalid_ff   <= bvalid_in;
         blast_ff    <= blast_in;
         brepl_ff    <= brepl_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      buf_ff <= buf_in;
   end

   `SSR_ASSERT_ALWAYS(a_no_accept_over_burst, clock, reset, !(req_fire && (blen_ff > BURST_W'(1))), "word accepted while burst still pending")
   `SSR_ASSERT_ALWAYS(a_window_bound, clock, reset, cnt_ff <= CNT_W'(PATTERN_MAX), "window count beyond pattern maximum")
   `SSR_ASSERT_NEXT(a_end_clears, clock, reset, req_fire && req_ch.in_last, (cnt_ff == '0) && !done_ff, "string end did not clear window state")
   `SSR_ASSERT_ALWAYS(a_marker_is_final, clock, reset, !(rsp_valid && !bvalid_ff) || final_rsp, "end marker on a non-final result")

endmodule
